[hw/rtl/brw_pkg.sv]
// ----------------------------------------------------------------------------
// brw_pkg: shared definitions for the bit stream reader/writer
// Store geometry, field widths, operation and error codes, memory write bus.
// ----------------------------------------------------------------------------
package brw_pkg;

  // Store geometry
  localparam int STORE_BYTES    = 4096;
  localparam int MAX_FIELD_BITS = 64;
  localparam int CAP_BITS       = STORE_BYTES * 8;
  localparam int ADDR_W         = $clog2(STORE_BYTES);
  localparam int FILL_W         = $clog2(STORE_BYTES + 1);

  // Field widths
  localparam int CUR_W   = 16;
  localparam int CNT_W   = 7;
  localparam int VAL_W   = 64;
  localparam int SEEK_W  = 17;

  // Byte window spanned by one field: the field plus a partial leading byte
  localparam int WIN_W   = MAX_FIELD_BITS + 8;
  localparam int SHAMT_W = $clog2(WIN_W);
  localparam int NB_W    = $clog2(MAX_FIELD_BITS / 8 + 2);

  typedef enum logic [1:0] {
    OP_READ     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_SEEK_ABS = 2'd2,
    OP_SEEK_REL = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK           = 2'd0,
    ERR_PAST_FILL    = 2'd1,
    ERR_BEFORE_START = 2'd2,
    ERR_PAST_CAP     = 2'd3
  } err_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

endpackage

[hw/rtl/brw_shift.sv]
// ----------------------------------------------------------------------------
// brw_shift: shared window shifter
// One logical right shifter; left shifts go through bit reversal on both sides.
// ----------------------------------------------------------------------------
module brw_shift (
  input  logic [brw_pkg::WIN_W-1:0]   data_i,
  input  logic [brw_pkg::SHAMT_W-1:0] amount_i,
  input  logic                        left_i,
  output logic [brw_pkg::WIN_W-1:0]   data_o
);
  import brw_pkg::*;

  logic [WIN_W-1:0] pre;
  logic [WIN_W-1:0] shifted;

  always_comb begin
    for (int i = 0; i < WIN_W; i++) begin
      pre[i] = left_i ? data_i[WIN_W-1-i] : data_i[i];
    end
    shifted = pre >> amount_i;
    for (int i = 0; i < WIN_W; i++) begin
      data_o[i] = left_i ? shifted[WIN_W-1-i] : shifted[i];
    end
  end

endmodule

[hw/rtl/brw_store.sv]
// ----------------------------------------------------------------------------
// brw_store: byte-wide stream store
// One write port and one read port, read data registered. Contents undefined
// until written.
// ----------------------------------------------------------------------------
module brw_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [brw_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]                rd_data_o,
  input  brw_pkg::mem_wr_t          wr_i
);
  import brw_pkg::*;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hw/rtl/bitstream_reader_writer_core.sv]
// ----------------------------------------------------------------------------
// bitstream_reader_writer_core: MSB-first bit stream reader/writer
// Byte store with a bit cursor; read, write, seek absolute, seek relative.
// ----------------------------------------------------------------------------
// Each accepted transfer is one operation and gives exactly one result
// transfer. Reads and writes of N bits at cursor C walk the bytes spanned by
// the field, ceil((C mod 8 + N) / 8) of them (1 to 9), through the byte-wide
// store read and write ports, one byte a cycle with the read of the next byte
// overlapping the merge and write-back of the current one. Such an operation
// keeps the input stalled through setup, the store walk, finish and result
// load; seeks, zero-count operations and rejected operations go from setup
// straight to result load. One shared 72-bit shifter aligns the write data
// into the byte window at setup and extracts the read field from the gathered
// bytes at finish. A new item can be taken while the previous result still
// sits unaccepted in the output register; the next result waits in the
// result load step until that register frees up.
// Errors give a zero read value and leave cursor, store and fill untouched.
// Bytes below the fill length that were never written read as unknown data.
// ----------------------------------------------------------------------------
module bitstream_reader_writer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        opcode_i,
  input  logic [brw_pkg::CNT_W-1:0]         bit_count_i,
  input  logic [brw_pkg::VAL_W-1:0]         write_value_i,
  input  logic signed [brw_pkg::SEEK_W-1:0] seek_amount_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [brw_pkg::VAL_W-1:0]         read_value_o,
  output logic [1:0]                        error_code_o,
  output logic [brw_pkg::CUR_W-1:0]         cursor_position_o
);
  import brw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_XFER,
    ST_FINISH,
    ST_DONE
  } state_e;

  localparam logic [WIN_W-1:0] ONES_WIN = '1;
  localparam logic [VAL_W-1:0] ONES_VAL = '1;

  // control state
  state_e            state_q, state_d;
  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [NB_W-1:0]   cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  op_e                      op_q, op_d;
  logic [CNT_W-1:0]         n_q, n_d;
  logic [VAL_W-1:0]         wv_q, wv_d;
  logic signed [SEEK_W-1:0] amt_q, amt_d;
  logic [ADDR_W-1:0]        base_q, base_d;
  logic [2:0]               off_q, off_d;
  logic [NB_W-1:0]          nb_q, nb_d;
  logic [ADDR_W-1:0]        wr_addr_q, wr_addr_d;
  logic                     old_ok_q, old_ok_d;
  logic [WIN_W-1:0]         win_q, win_d;
  logic [WIN_W-1:0]         wmask_q, wmask_d;
  logic [WIN_W-1:0]         acc_q, acc_d;
  logic [VAL_W-1:0]         fmask_q, fmask_d;
  logic [VAL_W-1:0]         res_rv_q, res_rv_d;
  err_e                     res_err_q, res_err_d;
  logic [VAL_W-1:0]         out_rv_q, out_rv_d;
  err_e                     out_err_q, out_err_d;
  logic [CUR_W-1:0]         out_cur_q, out_cur_d;

  // combinational helpers
  logic                     accept_in;
  logic                     out_free;
  logic [CNT_W-1:0]         n_sat;
  logic [2:0]               off_c;
  logic [CNT_W-1:0]         span;
  logic [CNT_W-1:0]         span_up;
  logic [CUR_W:0]           end_pos;
  logic signed [SEEK_W:0]   target;
  logic [7:0]               wsh_full;
  logic [7:0]               rsh_full;
  logic                     issue;
  logic [ADDR_W-1:0]        rd_addr;
  logic [7:0]               rd_data;
  logic [7:0]               old_byte;
  logic [FILL_W-1:0]        fill_end;
  mem_wr_t                  mem_wr;

  // shared shifter
  logic                     sh_left;
  logic [WIN_W-1:0]         sh_data;
  logic [SHAMT_W-1:0]       sh_amt;
  logic [WIN_W-1:0]         sh_out;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept_in  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign n_sat = (bit_count_i > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : bit_count_i;

  // setup arithmetic from the cursor at the start of the operation, plus the read extract shift used at finish
  assign off_c    = cursor_q[2:0];
  assign span     = CNT_W'(off_c) + n_q;
  assign span_up  = span + CNT_W'(7);
  assign end_pos  = {1'b0, cursor_q} + (CUR_W + 1)'(n_q);
  assign target   = (op_q == OP_SEEK_ABS) ? (SEEK_W + 1)'(amt_q)
                  : $signed({2'b00, cursor_q}) + (SEEK_W + 1)'(amt_q);
  assign wsh_full = 8'(WIN_W) - 8'(off_c) - 8'(n_q);
  assign rsh_full = 8'({nb_q, 3'b000}) - 8'(off_q) - 8'(n_q);

  assign sh_left = (state_q == ST_SETUP);
  assign sh_data = sh_left ? {8'h00, wv_q} : acc_q;
  assign sh_amt  = sh_left ? wsh_full[SHAMT_W-1:0] : rsh_full[SHAMT_W-1:0];

  brw_shift u_shift (
    .data_i   (sh_data),
    .amount_i (sh_amt),
    .left_i   (sh_left),
    .data_o   (sh_out)
  );

  // store walk
  assign issue    = (state_q == ST_XFER) && (cnt_q != nb_q);
  assign rd_addr  = base_q + ADDR_W'(cnt_q);
  assign old_byte = old_ok_q ? rd_data : 8'h00;
  assign fill_end = FILL_W'(base_q) + FILL_W'(nb_q);

  always_comb begin
    mem_wr.en   = (state_q == ST_XFER) && pend_q && (op_q == OP_WRITE);
    mem_wr.addr = wr_addr_q;
    mem_wr.data = (old_byte & ~wmask_q[WIN_W-1 -: 8]) | (win_q[WIN_W-1 -: 8] & wmask_q[WIN_W-1 -: 8]);
  end

  brw_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (mem_wr)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    n_d         = n_q;
    wv_d        = wv_q;
    amt_d       = amt_q;
    base_d      = base_q;
    off_d       = off_q;
    nb_d        = nb_q;
    wr_addr_d   = wr_addr_q;
    old_ok_d    = old_ok_q;
    win_d       = win_q;
    wmask_d     = wmask_q;
    acc_d       = acc_q;
    fmask_d     = fmask_q;
    res_rv_d    = res_rv_q;
    res_err_d   = res_err_q;
    out_rv_d    = out_rv_q;
    out_err_d   = out_err_q;
    out_cur_d   = out_cur_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept_in) begin
          op_d    = op_e'(opcode_i);
          n_d     = n_sat;
          wv_d    = write_value_i;
          amt_d   = seek_amount_i;
          state_d = ST_SETUP;
        end
      end

      ST_SETUP: begin
        res_rv_d  = '0;
        res_err_d = ERR_OK;
        base_d    = cursor_q[ADDR_W+2:3];
        off_d     = off_c;
        nb_d      = NB_W'(span_up >> 3);
        cnt_d     = '0;
        pend_d    = 1'b0;
        win_d     = sh_out;
        wmask_d   = (ONES_WIN >> off_c) & ~(ONES_WIN >> span);
        fmask_d   = ONES_VAL >> (CNT_W'(MAX_FIELD_BITS) - n_q);
        acc_d     = '0;
        state_d   = ST_DONE;
        case (op_q)
          OP_READ: begin
            if (n_q != '0) begin
              if (end_pos > (CUR_W + 1)'({fill_q, 3'b000})) begin
                res_err_d = ERR_PAST_FILL;
              end else begin
                state_d = ST_XFER;
              end
            end
          end
          OP_WRITE: begin
            if (n_q != '0) begin
              if (end_pos > (CUR_W + 1)'(CAP_BITS)) begin
                res_err_d = ERR_PAST_CAP;
              end else begin
                state_d = ST_XFER;
              end
            end
          end
          default: begin
            if (target < 0) begin
              res_err_d = ERR_BEFORE_START;
            end else if (target > $signed((SEEK_W + 1)'(CAP_BITS))) begin
              res_err_d = ERR_PAST_CAP;
            end else begin
              cursor_d = target[CUR_W-1:0];
            end
          end
        endcase
      end

      ST_XFER: begin
        // read of byte cnt overlaps merge/write-back of the byte before it
        pend_d = issue;
        if (issue) begin
          cnt_d     = cnt_q + NB_W'(1);
          wr_addr_d = rd_addr;
          old_ok_d  = (FILL_W'(rd_addr) < fill_q);
        end
        if (pend_q) begin
          acc_d   = {acc_q[WIN_W-9:0], rd_data};
          win_d   = win_q << 8;
          wmask_d = wmask_q << 8;
        end
        if (!issue) begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        cursor_d = cursor_q + CUR_W'(n_q);
        if (op_q == OP_READ) begin
          res_rv_d = sh_out[VAL_W-1:0] & fmask_q;
        end else if (fill_end > fill_q) begin
          fill_d = fill_end;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = res_rv_q;
          out_err_d   = res_err_q;
          out_cur_d   = cursor_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    n_q       <= n_d;
    wv_q      <= wv_d;
    amt_q     <= amt_d;
    base_q    <= base_d;
    off_q     <= off_d;
    nb_q      <= nb_d;
    wr_addr_q <= wr_addr_d;
    old_ok_q  <= old_ok_d;
    win_q     <= win_d;
    wmask_q   <= wmask_d;
    acc_q     <= acc_d;
    fmask_q   <= fmask_d;
    res_rv_q  <= res_rv_d;
    res_err_q <= res_err_d;
    out_rv_q  <= out_rv_d;
    out_err_q <= out_err_d;
    out_cur_q <= out_cur_d;
  end

  assign out_valid_o       = out_valid_q;
  assign read_value_o      = out_rv_q;
  assign error_code_o      = out_err_q;
  assign cursor_position_o = out_cur_q;

`ifndef SYNTHESIS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CUR_W'(CAP_BITS))
    else $error("cursor beyond store capacity");

  a_error_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_OK) |-> (read_value_o == '0))
    else $error("nonzero read value with error");

  a_store_write_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr.en |-> (op_q == OP_WRITE) && (res_err_q == ERR_OK))
    else $error("store written outside a write operation");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !$stable(state_q))
    else $error("input not stalled after accept");
`endif

endmodule

[test/brw_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brw_stream_checker: outcome predictor and scoreboard for the bit stream core
// Keeps its own byte store, fill length and cursor, works out the outcome of
// every operation transfer and compares each result transfer with the oldest.
// ----------------------------------------------------------------------------
module brw_stream_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        opcode_i,
  input  logic [brw_pkg::CNT_W-1:0]         bit_count_i,
  input  logic [brw_pkg::VAL_W-1:0]         write_value_i,
  input  logic signed [brw_pkg::SEEK_W-1:0] seek_amount_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [brw_pkg::VAL_W-1:0]         read_value_i,
  input  logic [1:0]                        error_code_i,
  input  logic [brw_pkg::CUR_W-1:0]         cursor_position_i,
  output int                                mismatches_o,
  output int                                results_owed_o
);
  import brw_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] value;
    err_e             err;
    logic [CUR_W-1:0] cursor;
  } stream_outcome_t;

  logic [7:0]      store_copy [STORE_BYTES];
  int unsigned     fill_bytes;
  int unsigned     cursor_bits;
  stream_outcome_t outcomes_due [$];

  // Work out one operation against the local copy and queue its outcome.
  task automatic apply_stream_op(input op_e op, input int unsigned cnt,
                                 input logic [VAL_W-1:0] wv,
                                 input logic signed [SEEK_W-1:0] amt);
    stream_outcome_t res;
    int unsigned     n;
    int unsigned     pos;
    int unsigned     idx;
    int unsigned     i;
    longint          target;
    logic [7:0]      merged;
    res.value = '0;
    res.err   = ERR_OK;
    n = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : cnt;
    case (op)
      OP_READ: begin
        if (n != 0) begin
          if (cursor_bits + n > fill_bytes * 8) begin
            res.err = ERR_PAST_FILL;
          end else begin
            for (i = 0; i < n; i++) begin
              pos = cursor_bits + i;
              res.value = {res.value[VAL_W-2:0], store_copy[pos >> 3][7 - (pos & 7)]};
            end
            cursor_bits += n;
          end
        end
      end
      OP_WRITE: begin
        if (n != 0) begin
          if (cursor_bits + n > CAP_BITS) begin
            res.err = ERR_PAST_CAP;
          end else begin
            for (i = 0; i < n; i++) begin
              pos = cursor_bits + i;
              idx = pos >> 3;
              // bytes at or past the fill length merge as zero
              merged = (idx < fill_bytes) ? store_copy[idx] : 8'h00;
              merged[7 - (pos & 7)] = wv[n - 1 - i];
              store_copy[idx] = merged;
              if (idx >= fill_bytes) fill_bytes = idx + 1;
            end
            cursor_bits += n;
          end
        end
      end
      default: begin
        target = (op == OP_SEEK_ABS) ? longint'(amt)
                                     : longint'(cursor_bits) + longint'(amt);
        if (target < 0) begin
          res.err = ERR_BEFORE_START;
        end else if (target > CAP_BITS) begin
          res.err = ERR_PAST_CAP;
        end else begin
          cursor_bits = 32'(target);
        end
      end
    endcase
    res.cursor = cursor_bits[CUR_W-1:0];
    outcomes_due.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    stream_outcome_t due;
    if (!rst_ni) begin
      fill_bytes     = 0;
      cursor_bits    = 0;
      outcomes_due.delete();
      mismatches_o   = 0;
      results_owed_o = 0;
    end else begin
      // results first: a result leaving at this edge belongs to an older transfer
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          $error("result transfer with no operation outstanding");
          mismatches_o++;
        end else begin
          due = outcomes_due.pop_front();
          if (read_value_i !== due.value) begin
            $error("read_value mismatch: expected %h, actual %h", due.value, read_value_i);
            mismatches_o++;
          end
          if (error_code_i !== due.err) begin
            $error("error_code mismatch: expected %0d, actual %0d", due.err, error_code_i);
            mismatches_o++;
          end
          if (cursor_position_i !== due.cursor) begin
            $error("cursor_position mismatch: expected %0d, actual %0d",
                   due.cursor, cursor_position_i);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_stream_op(op_e'(opcode_i), 32'(bit_count_i), write_value_i, seek_amount_i);
      end
      results_owed_o = outcomes_due.size();
    end
  end

endmodule

[test/tb_bitstream_reader_writer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitstream_reader_writer_core: testbench for the bit stream reader/writer
// Directed corner operations, then random operation mixes with bursty input
// and a stalling result side; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_bitstream_reader_writer_core;
  import brw_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int N_RANDOM   = 1875;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               opcode;
  logic [CNT_W-1:0]         bit_count;
  logic [VAL_W-1:0]         write_value;
  logic signed [SEEK_W-1:0] seek_amount;
  logic                     out_valid;
  logic                     out_stall;
  logic [VAL_W-1:0]         read_value;
  logic [1:0]               error_code;
  logic [CUR_W-1:0]         cursor_position;
  int                       mismatches;
  int                       results_owed;

  // Stimulus-side view of the stream: where the cursor will be and which
  // store bits hold defined data, so that no read touches never-written bits.
  int plan_cursor;
  int plan_fill;
  bit bit_known [CAP_BITS];
  int burst_left;

  bitstream_reader_writer_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (opcode),
    .bit_count_i       (bit_count),
    .write_value_i     (write_value),
    .seek_amount_i     (seek_amount),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .read_value_o      (read_value),
    .error_code_o      (error_code),
    .cursor_position_o (cursor_position)
  );

  brw_stream_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .opcode_i          (opcode),
    .bit_count_i       (bit_count),
    .write_value_i     (write_value),
    .seek_amount_i     (seek_amount),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .read_value_i      (read_value),
    .error_code_i      (error_code),
    .cursor_position_i (cursor_position),
    .mismatches_o      (mismatches),
    .results_owed_o    (results_owed)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Mostly legal counts, with zero and the saturating range mixed in.
  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(65, 127);
    if (r == 2) return MAX_FIELD_BITS;
    return $urandom_range(1, MAX_FIELD_BITS);
  endfunction

  // Early on, a seek that would land far past the data is turned into one
  // before the start, so the store does not get a huge gap too soon.
  function automatic logic signed [SEEK_W-1:0] keep_near(input op_e op,
                                                       input logic signed [SEEK_W-1:0] amt);
    longint tgt;
    tgt = (op == OP_SEEK_ABS) ? longint'(amt) : longint'(plan_cursor) + longint'(amt);
    if (tgt > plan_fill * 8 + 64 && tgt <= CAP_BITS) amt[SEEK_W-1] = ~amt[SEEK_W-1];
    return amt;
  endfunction

  // Offer one operation, track its effect on the plan, wait for the transfer,
  // then idle the input for a random gap, which may be zero, if the current burst is used up.
  task automatic send_op(input op_e op, input int cnt, input logic [VAL_W-1:0] wv,
                         input logic signed [SEEK_W-1:0] amt);
    int     n;
    int     pos;
    int     idx;
    int     b;
    int     gap;
    longint tgt;
    bit     safe;
    op_e    eff_op;
    n = (cnt > MAX_FIELD_BITS) ? MAX_FIELD_BITS : cnt;
    eff_op = op;
    if (op == OP_READ && n != 0 && plan_cursor + n <= plan_fill * 8) begin
      safe = 1'b1;
      for (pos = plan_cursor; pos < plan_cursor + n; pos++) begin
        if (!bit_known[pos]) safe = 1'b0;
      end
      // a read over undefined bits becomes a write that defines them
      if (!safe) eff_op = OP_WRITE;
    end
    case (eff_op)
      OP_READ: begin
        if (n != 0 && plan_cursor + n <= plan_fill * 8) plan_cursor += n;
      end
      OP_WRITE: begin
        if (n != 0 && plan_cursor + n <= CAP_BITS) begin
          for (pos = plan_cursor; pos < plan_cursor + n; pos++) begin
            idx = pos / 8;
            if (idx >= plan_fill) begin
              // fresh byte: the untouched bits merge in as zero
              for (b = 0; b < 8; b++) bit_known[idx * 8 + b] = 1'b1;
              plan_fill = idx + 1;
            end
            bit_known[pos] = 1'b1;
          end
          plan_cursor += n;
        end
      end
      default: begin
        tgt = (eff_op == OP_SEEK_ABS) ? longint'(amt)
                                      : longint'(plan_cursor) + longint'(amt);
        if (tgt >= 0 && tgt <= CAP_BITS) plan_cursor = 32'(tgt);
      end
    endcase

    in_valid    <= 1'b1;
    opcode      <= eff_op;
    bit_count   <= cnt[CNT_W-1:0];
    write_value <= wv;
    seek_amount <= amt;
    do @(posedge clk); while (in_stall);

    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Result side: segments of no stall, light stall, heavy stall, and long
  // hold-offs; the fourth segment is always a hold-off so the core backs up.
  initial begin : result_sink
    int seg;
    int len;
    int mode;
    int c;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    seg = 0;
    forever begin
      if (seg == 3 || $urandom_range(0, 14) == 0) mode = 3;
      else mode = $urandom_range(0, 2);
      len = (mode == 3) ? $urandom_range(150, 300) : $urandom_range(20, 200);
      for (c = 0; c < len; c++) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ($urandom_range(0, 99) < 80);
          default: out_stall <= 1'b1;
        endcase
      end
      seg++;
    end
  end

  initial begin : stimulus
    int                       k;
    int                       sel;
    int                       r;
    int                       tgt;
    int                       wait_cycles;
    bit                       late;
    op_e                      op;
    logic signed [SEEK_W-1:0] amt;
    in_valid    = 1'b0;
    opcode      = OP_READ;
    bit_count   = '0;
    write_value = '0;
    seek_amount = '0;
    rst_n       = 1'b0;
    plan_cursor = 0;
    plan_fill   = 0;
    burst_left  = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    send_op(OP_READ, 8, 64'h0, '0);                        // read from an empty store
    send_op(OP_WRITE, 0, 64'hFFFF_FFFF_FFFF_FFFF, '0);     // zero-count write
    send_op(OP_READ, 0, 64'h0, '0);                        // zero-count read
    send_op(OP_WRITE, 64, 64'hFFFF_FFFF_FFFF_FFFF, '0);    // widest write
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(3));
    send_op(OP_WRITE, 5, 64'h15, '0);                      // merge inside one byte
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(0));
    send_op(OP_READ, 64, 64'h0, '0);                       // widest read
    send_op(OP_READ, 1, 64'h0, '0);                        // one bit past the fill
    send_op(OP_WRITE, 127, {$urandom, $urandom}, '0);      // count saturates
    send_op(OP_WRITE, 3, 64'h0, '0);                       // fresh byte merges as zero
    send_op(OP_SEEK_REL, 0, 64'h0, 17'(-200));             // before the start
    send_op(OP_SEEK_REL, 0, 64'h0, 17'(-67));
    send_op(OP_READ, 100, 64'h0, '0);                      // saturating read
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(-1));
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(CAP_BITS + 1));     // just past capacity
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(CAP_BITS));         // exactly at capacity
    send_op(OP_WRITE, 1, 64'h1, '0);                       // write past capacity
    send_op(OP_READ, 0, 64'h0, '0);
    send_op(OP_SEEK_REL, 0, 64'h0, 17'(1));
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'h0FFFF);             // largest positive amount
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'h10000);             // most negative amount
    send_op(OP_SEEK_REL, 0, 64'h0, 17'(-CAP_BITS));        // back to zero
    send_op(OP_SEEK_ABS, 0, 64'h0, 17'(CAP_BITS - 8));
    send_op(OP_WRITE, 9, {$urandom, $urandom}, '0);        // straddles capacity

    // Random mix; seeks mostly land inside the data so reads succeed.
    // Near the end, writes may reach the top of the store and leave gaps.
    for (k = 0; k < N_RANDOM; k++) begin
      late = (k > N_RANDOM * 4 / 5);
      sel  = $urandom_range(0, 99);
      amt  = SEEK_W'($urandom);
      if (sel < 35) begin
        op = OP_WRITE;
      end else if (sel < 65) begin
        op = OP_READ;
      end else if (sel < 90) begin
        op = OP_SEEK_ABS;
        r  = $urandom_range(0, 9);
        if (r < 7) begin
          tgt = $urandom_range(0, plan_fill * 8);
          amt = 17'(tgt);
        end else if (r == 7 && late) begin
          tgt = $urandom_range(CAP_BITS - 72, CAP_BITS + 2);
          amt = 17'(tgt);
        end
      end else begin
        op = OP_SEEK_REL;
        if ($urandom_range(0, 9) < 8) amt = 17'($urandom_range(0, 160) - 80);
      end
      if (!late && (op == OP_SEEK_ABS || op == OP_SEEK_REL)) amt = keep_near(op, amt);
      send_op(op, pick_count(), {$urandom, $urandom}, amt);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (results_owed != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    // room for a late extra result to show up
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 600000);
    $display("Verification failed");
    $finish;
  end

endmodule
